// ===== src/fault_event_recorder_macros.svh =====
// Assertion helpers for the fault event recorder.
// Every check is sampled on the rising clock and is held off during reset.
`ifndef FAULT_EVENT_RECORDER_MACROS_SVH
`define FAULT_EVENT_RECORDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FER_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FER_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/fer_pkg.sv =====
`timescale 1ns / 1ps
package fer_pkg;

   // Ring depth must be a power of two: the read offset wraps by truncation.
   localparam int RECORD_DEPTH = 512;
   localparam int EVENT_COUNT  = 16;

   localparam int PTR_W    = $clog2(RECORD_DEPTH);
   localparam int EV_IDX_W = $clog2(EVENT_COUNT);

   typedef logic [PTR_W-1:0]    ptr_type;
   typedef logic [EV_IDX_W-1:0] ev_idx_type;
   typedef logic [8:0]          pos_type;

   // Command codes carried in a request word
   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_EVENT   = 3'd1,
      CMD_STARTUP = 3'd2,
      CMD_READ    = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   // Control register indexes
   typedef enum logic [1:0] {
      CSR_MIN_REPEAT   = 2'd0,
      CSR_STARTUP_CODE = 2'd1,
      CSR_SLEEP_CODE   = 2'd2,
      CSR_CBC_CODE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [2:0] command;
      logic [3:0] event_id;
      logic [7:0] level;
      logic       store_ok;
      logic [8:0] read_offset;
   } req_type;

   typedef struct packed {
      logic       saved;
      logic [3:0] rec_event;
      logic [7:0] rec_delta;
      pos_type    write_position;
   } rsp_type;

   // One ring entry
   typedef struct packed {
      logic [3:0] rec_event;
      logic [7:0] rec_delta;
   } record_type;

   // Ring control from the event logic
   typedef struct packed {
      logic       push;
      logic       clear;
      record_type record;
   } ring_ctrl_type;

endpackage

// ===== src/fault_event_recorder.sv =====
`timescale 1ns / 1ps
// Fault event recorder.
// Request channel: a command word on req_word is taken at a rising edge with
// start high; busy is always low, so one word can be taken every cycle.
// Commands: tick a second, report an event, request startup, read a record
// by age (0 is newest) and clear the log.
// Response channel: every taken word gives exactly one response word on
// rsp_word, marked by rsp_valid for one cycle, in the cycle after the request.
// The receiver cannot hold a response off; none is needed, since the next
// request's response comes in a later cycle.
// Throughput is one command per cycle. The command logic, the hour mapping
// multiply and the record memory port all fit between the request edge and
// the response register.
// The user writes the control registers (csr_write_en/csr_index/csr_wdata)
// only while no command is in flight; the block itself does not enforce it.
// Synchronous reset restores the register defaults, zeroes the counters,
// latches and pointer; the record memory is not swept: entries not written
// since reset or the last clear read back as zero.
module fault_event_recorder (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fer_pkg::req_type req_word,
   output logic             rsp_valid,
   output fer_pkg::rsp_type rsp_word,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [16:0]      csr_wdata
);

   // Delta mapping: ceil(x / 3600) as ((x + 3599) >> 4) / 225, the divide by
   // 225 done as a multiply by ceil(2^24 / 225) and a shift
   localparam logic [31:0] SHORT_LIMIT = 32'd60;
   localparam logic [31:0] LONG_LIMIT  = 32'd604800;
   localparam logic [19:0] HOUR_ROUND  = 20'd3599;
   localparam logic [31:0] HOUR_RECIP  = 32'd74566;
   localparam logic [7:0]  DELTA_SHORT = 8'd171;
   localparam logic [7:0]  DELTA_LONG  = 8'd170;

   logic accept;

   // Control registers
   logic [16:0] min_repeat_ff;
   logic [3:0]  startup_code_ff, sleep_code_ff, cbc_code_ff;

   // Event state
   logic [31:0] interval_ff, interval_in;
   logic [31:0] uptime_ff, uptime_in;
   logic [31:0] last_time_ff [fer_pkg::EVENT_COUNT];
   logic [31:0] last_time_in [fer_pkg::EVENT_COUNT];
   logic [fer_pkg::EVENT_COUNT-1:0] last_valid_ff, last_valid_in;
   logic [fer_pkg::EVENT_COUNT-1:0] latched_ff, latched_in;
   logic [7:0]  cbc_level_ff, cbc_level_in;
   logic        startup_pending_ff, startup_pending_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_read_ff, rsp_read_in;
   logic        rsp_saved_ff, rsp_saved_in;
   logic [3:0]  rsp_event_ff, rsp_event_in;
   logic [7:0]  rsp_delta_ff, rsp_delta_in;

   // Decode
   logic                   cmd_event;
   fer_pkg::ev_idx_type    ev_idx;
   logic                   ev_in_range;
   logic                   is_startup, is_sleep, is_cbc, is_plain;
   logic [31:0]            since_save;
   logic                   repeat_block, save_ok, attempt, do_save;
   logic [19:0]            round_up;
   logic [31:0]            hour_prod;
   logic [7:0]             hour_delta, delta;

   fer_pkg::ring_ctrl_type ring_ctrl;
   fer_pkg::ptr_type       ring_ptr;
   fer_pkg::record_type    ring_rd;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_repeat_ff   <= '0;
         startup_code_ff <= 4'd0;
         sleep_code_ff   <= 4'd1;
         cbc_code_ff     <= 4'd2;
      end else if (csr_write_en) begin
         case (csr_index)
            fer_pkg::CSR_MIN_REPEAT:   min_repeat_ff   <= csr_wdata;
            fer_pkg::CSR_STARTUP_CODE: startup_code_ff <= csr_wdata[3:0];
            fer_pkg::CSR_SLEEP_CODE:   sleep_code_ff   <= csr_wdata[3:0];
            fer_pkg::CSR_CBC_CODE:     cbc_code_ff     <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Event kind; earlier codes take priority when codes collide
   assign cmd_event   = (req_word.command == fer_pkg::CMD_EVENT);
   assign ev_idx      = fer_pkg::ev_idx_type'(req_word.event_id);
   assign ev_in_range = (32'(req_word.event_id) < fer_pkg::EVENT_COUNT);
   assign is_startup  = (req_word.event_id == startup_code_ff);
   assign is_sleep    = !is_startup && (req_word.event_id == sleep_code_ff);
   assign is_cbc      = !is_startup && !is_sleep && (req_word.event_id == cbc_code_ff);
   assign is_plain    = !is_startup && !is_sleep && !is_cbc;

   // Repeat limit never applies to startup or sleep
   assign since_save   = uptime_ff - last_time_ff[ev_idx];
   assign repeat_block = !is_startup && !is_sleep && last_valid_ff[ev_idx]
                         && (since_save < 32'(min_repeat_ff));
   assign save_ok      = ev_in_range && !repeat_block && req_word.store_ok;

   always_comb begin
      attempt = 1'b0;
      if (is_startup) begin
         attempt = startup_pending_ff;
      end else if (is_sleep) begin
         attempt = 1'b1;
      end else if (is_cbc) begin
         attempt = (cbc_level_ff != req_word.level);
      end else begin
         attempt = ev_in_range && !latched_ff[ev_idx] && (req_word.level != 8'd0);
      end
   end

   assign do_save = accept && cmd_event && attempt && save_ok;

   // Interval to hours
   assign round_up   = interval_ff[19:0] + HOUR_ROUND;
   assign hour_prod  = 32'(round_up[19:4]) * HOUR_RECIP;
   assign hour_delta = hour_prod[31:24];

   always_comb begin
      if (is_startup) begin
         delta = 8'd0;
      end else if (interval_ff <= SHORT_LIMIT) begin
         delta = DELTA_SHORT;
      end else if (interval_ff <= LONG_LIMIT) begin
         delta = hour_delta;
      end else begin
         delta = DELTA_LONG;
      end
   end

   assign ring_ctrl.push             = do_save;
   assign ring_ctrl.clear            = accept && (req_word.command == fer_pkg::CMD_CLEAR);
   assign ring_ctrl.record.rec_event = req_word.event_id;
   assign ring_ctrl.record.rec_delta = delta;

   // Next state
   always_comb begin
      interval_in        = interval_ff;
      uptime_in          = uptime_ff;
      last_time_in       = last_time_ff;
      last_valid_in      = last_valid_ff;
      latched_in         = latched_ff;
      cbc_level_in       = cbc_level_ff;
      startup_pending_in = startup_pending_ff;
      rsp_valid_in       = accept;
      rsp_read_in        = accept && (req_word.command == fer_pkg::CMD_READ);
      rsp_saved_in       = do_save;
      rsp_event_in       = do_save ? req_word.event_id : 4'd0;
      rsp_delta_in       = do_save ? delta : 8'd0;
      if (accept) begin
         case (req_word.command)
            fer_pkg::CMD_TICK: begin
               interval_in = interval_ff + 32'd1;
               uptime_in   = uptime_ff + 32'd1;
            end
            fer_pkg::CMD_EVENT: begin
               if (do_save) begin
                  interval_in            = '0;
                  last_time_in[ev_idx]   = uptime_ff;
                  last_valid_in[ev_idx]  = 1'b1;
                  if (is_startup) begin
                     startup_pending_in = 1'b0;
                  end
                  if (is_cbc) begin
                     cbc_level_in = req_word.level;
                  end
                  if (is_plain) begin
                     latched_in[ev_idx] = 1'b1;
                  end
               end else if (is_plain && ev_in_range && latched_ff[ev_idx]
                            && (req_word.level == 8'd0)) begin
                  // re-arm on return to zero, no record
                  latched_in[ev_idx] = 1'b0;
               end
            end
            fer_pkg::CMD_STARTUP: begin
               startup_pending_in = 1'b1;
            end
            fer_pkg::CMD_CLEAR: begin
               latched_in    = '0;
               last_valid_in = '0;
               cbc_level_in  = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff        <= '0;
         uptime_ff          <= '0;
         last_valid_ff      <= '0;
         latched_ff         <= '0;
         cbc_level_ff       <= '0;
         startup_pending_ff <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         rsp_read_ff        <= 1'b0;
      end else begin
         interval_ff        <= interval_in;
         uptime_ff          <= uptime_in;
         last_valid_ff      <= last_valid_in;
         latched_ff         <= latched_in;
         cbc_level_ff       <= cbc_level_in;
         startup_pending_ff <= startup_pending_in;
         rsp_valid_ff       <= rsp_valid_in;
         rsp_read_ff        <= rsp_read_in;
      end
   end

   // Save times and response payload
   always_ff @(posedge clock) begin
      last_time_ff <= last_time_in;
      rsp_saved_ff <= rsp_saved_in;
      rsp_event_ff <= rsp_event_in;
      rsp_delta_ff <= rsp_delta_in;
   end

   fer_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ring_ctrl),
      .rd_offset (req_word.read_offset),
      .wr_ptr    (ring_ptr),
      .rd_record (ring_rd)
   );

   // Response word; a read takes its record from the ring's read register
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_word.saved          = rsp_saved_ff;
   assign rsp_word.rec_event      = rsp_read_ff ? ring_rd.rec_event : rsp_event_ff;
   assign rsp_word.rec_delta      = rsp_read_ff ? ring_rd.rec_delta : rsp_delta_ff;
   assign rsp_word.write_position = fer_pkg::pos_type'(ring_ptr);

   `include "fault_event_recorder_macros.svh"

   `FER_ASSERT_NEXT(a_rsp_follows_req, accept, rsp_valid_ff, "response missing after request")
   `FER_ASSERT_SAME(a_save_moves_ptr, rsp_valid_ff && rsp_saved_ff, !$stable(ring_ptr),
                    "saved record did not advance the pointer")
   `FER_ASSERT_SAME(a_save_zeroes_interval, rsp_valid_ff && rsp_saved_ff, interval_ff == '0,
                    "interval not restarted by a save")
   `FER_ASSERT_SAME(a_read_not_saved, rsp_read_ff, !rsp_saved_ff && rsp_valid_ff,
                    "read response flagged as a save")

endmodule

// ===== src/fer_ring.sv =====
`timescale 1ns / 1ps
module fer_ring (
   input  logic                   clock,
   input  logic                   reset,
   input  fer_pkg::ring_ctrl_type ctrl,
   input  logic [8:0]             rd_offset,
   output fer_pkg::ptr_type       wr_ptr,
   output fer_pkg::record_type    rd_record
);

   fer_pkg::record_type mem [fer_pkg::RECORD_DEPTH];

   fer_pkg::ptr_type    ptr_ff, ptr_in;
   logic                wrapped_ff, wrapped_in;
   fer_pkg::ptr_type    rd_idx;
   fer_pkg::record_type rd_data_ff;
   logic                rd_live_ff, rd_live_in;

   // Pointer advance and wrap tracking; entries at or past the pointer are
   // unwritten since the last clear until the pointer has wrapped once.
   always_comb begin
      ptr_in     = ptr_ff;
      wrapped_in = wrapped_ff;
      if (ctrl.clear) begin
         ptr_in     = '0;
         wrapped_in = 1'b0;
      end else if (ctrl.push) begin
         if (ptr_ff == fer_pkg::ptr_type'(fer_pkg::RECORD_DEPTH - 1)) begin
            ptr_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            ptr_in = ptr_ff + fer_pkg::ptr_type'(1);
         end
      end
   end

   // Newest-first address: one behind the pointer, minus the age
   assign rd_idx     = ptr_ff - fer_pkg::ptr_type'(1) - fer_pkg::ptr_type'(rd_offset);
   assign rd_live_in = wrapped_ff || (rd_idx < ptr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         wrapped_ff <= 1'b0;
         rd_live_ff <= 1'b0;
      end else begin
         ptr_ff     <= ptr_in;
         wrapped_ff <= wrapped_in;
         rd_live_ff <= rd_live_in;
      end
   end

   // Record memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[ptr_ff] <= ctrl.record;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign wr_ptr    = ptr_ff;
   assign rd_record = rd_live_ff ? rd_data_ff : '0;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

   // Watchdog, in clock cycles.
   localparam int unsigned CYCLE_LIMIT = 100_000;
   localparam int unsigned PHASE_WORDS = 390;

   // Command codes the block does not define
   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

   // Event codes after reset, and the top event id
   localparam fer_pkg::ev_idx_type EV_STARTUP_DFLT = 4'd0;
   localparam fer_pkg::ev_idx_type EV_SLEEP_DFLT   = 4'd1;
   localparam fer_pkg::ev_idx_type EV_CBC_DFLT     = 4'd2;
   localparam fer_pkg::ev_idx_type EV_TOP          = 4'd15;

   // Delta codes
   localparam logic [7:0] DELTA_NONE  = 8'd0;
   localparam logic [7:0] DELTA_SHORT = 8'd171;
   localparam logic [7:0] DELTA_LONG  = 8'd170;
   localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [31:0] SHORT_SECS    = 32'd60;
   localparam logic [31:0] LONG_SECS     = 32'd604800;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   fer_pkg::req_type req_word;
   logic             rsp_valid;
   fer_pkg::rsp_type rsp_word;
   logic             csr_write_en;
   logic [1:0]       csr_index;
   logic [16:0]      csr_wdata;

   fault_event_recorder u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Shadow of the recorder's registers and state
   logic [16:0]         cfg_min_repeat;
   fer_pkg::ev_idx_type cfg_startup;
   fer_pkg::ev_idx_type cfg_sleep;
   fer_pkg::ev_idx_type cfg_cbc;

   logic [31:0]         interval_secs;
   logic [31:0]         uptime_secs;
   logic [31:0]         save_time [fer_pkg::EVENT_COUNT];
   logic                save_valid [fer_pkg::EVENT_COUNT];
   logic                latched [fer_pkg::EVENT_COUNT];
   logic [7:0]          cbc_level;
   logic                startup_pending;
   fer_pkg::ptr_type    ring_ptr;
   fer_pkg::record_type ring [fer_pkg::RECORD_DEPTH];

   fer_pkg::rsp_type rsp_due_q[$];
   int unsigned      fail_count;
   int unsigned      cycle_count;
   int unsigned      words_taken;
   int unsigned      records_saved;
   int unsigned      reads_done;

   // Typed-in expectation for the directed word on the bus
   logic             use_typed;
   fer_pkg::rsp_type typed_rsp;

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
      fail_count++;
   endtask

   // Seconds since the last record mapped to ceiling hours
   function automatic logic [7:0] hours_of(logic [31:0] secs);
      if (secs <= SHORT_SECS)
         return DELTA_SHORT;
      if (secs <= LONG_SECS)
         return 8'((secs + SECS_PER_HOUR - 32'd1) / SECS_PER_HOUR);
      return DELTA_LONG;
   endfunction

   function automatic void wipe_log();
      for (int i = 0; i < fer_pkg::RECORD_DEPTH; i++)
         ring[i] = '0;
      for (int i = 0; i < fer_pkg::EVENT_COUNT; i++) begin
         latched[i]    = 1'b0;
         save_valid[i] = 1'b0;
         save_time[i]  = '0;
      end
      ring_ptr  = '0;
      cbc_level = '0;
   endfunction

   // Append a record unless the repeat limit or the store flag refuses it
   function automatic bit append_record(fer_pkg::ev_idx_type ev, logic ok,
                                        ref fer_pkg::rsp_type r);
      logic [31:0] since;
      logic [7:0]  delta;
      since = uptime_secs - save_time[ev];
      if (ev != cfg_startup && ev != cfg_sleep && save_valid[ev] &&
          since < {15'd0, cfg_min_repeat})
         return 1'b0;
      if (!ok)
         return 1'b0;
      delta = (ev == cfg_startup) ? DELTA_NONE : hours_of(interval_secs);
      ring[ring_ptr] = '{rec_event: ev, rec_delta: delta};
      ring_ptr = ring_ptr + fer_pkg::ptr_type'(1);
      interval_secs  = '0;
      save_time[ev]  = uptime_secs;
      save_valid[ev] = 1'b1;
      r.saved     = 1'b1;
      r.rec_event = ev;
      r.rec_delta = delta;
      return 1'b1;
   endfunction

   // Apply one command word to the shadow state, return the response word
   function automatic fer_pkg::rsp_type step_recorder(fer_pkg::req_type w);
      fer_pkg::rsp_type r;
      fer_pkg::ptr_type idx;
      r = '0;
      case (w.command)
         fer_pkg::CMD_TICK: begin
            interval_secs++;
            uptime_secs++;
         end
         fer_pkg::CMD_EVENT: begin
            if (w.event_id == cfg_startup) begin
               if (startup_pending)
                  if (append_record(w.event_id, w.store_ok, r))
                     startup_pending = 1'b0;
            end else if (w.event_id == cfg_sleep) begin
               void'(append_record(w.event_id, w.store_ok, r));
            end else if (w.event_id == cfg_cbc) begin
               if (cbc_level != w.level)
                  if (append_record(w.event_id, w.store_ok, r))
                     cbc_level = w.level;
            end else if (!latched[w.event_id]) begin
               if (w.level != 8'd0)
                  if (append_record(w.event_id, w.store_ok, r))
                     latched[w.event_id] = 1'b1;
            end else if (w.level == 8'd0) begin
               latched[w.event_id] = 1'b0;
            end
         end
         fer_pkg::CMD_STARTUP: startup_pending = 1'b1;
         fer_pkg::CMD_READ: begin
            idx = ring_ptr - fer_pkg::ptr_type'(1) - fer_pkg::ptr_type'(w.read_offset);
            r.rec_event = ring[idx].rec_event;
            r.rec_delta = ring[idx].rec_delta;
         end
         fer_pkg::CMD_CLEAR: wipe_log();
         default: ;
      endcase
      r.write_position = ring_ptr;
      return r;
   endfunction

   // Compare responses, track register writes, predict each taken word
   always @(posedge clock) begin : monitor
      fer_pkg::rsp_type want;
      fer_pkg::rsp_type got;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid) begin
            got = rsp_word;
            if (rsp_due_q.size() == 0) begin
               flag_mismatch("response with none pending", 32'(got), '0);
            end else begin
               want = rsp_due_q.pop_front();
               if (got.saved !== want.saved)
                  flag_mismatch("saved", 32'(got.saved), 32'(want.saved));
               if (got.rec_event !== want.rec_event)
                  flag_mismatch("rec_event", 32'(got.rec_event), 32'(want.rec_event));
               if (got.rec_delta !== want.rec_delta)
                  flag_mismatch("rec_delta", 32'(got.rec_delta), 32'(want.rec_delta));
               if (got.write_position !== want.write_position)
                  flag_mismatch("write_position", 32'(got.write_position),
                                32'(want.write_position));
               if (got.saved === 1'b1)
                  records_saved++;
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               fer_pkg::CSR_MIN_REPEAT:   cfg_min_repeat = csr_wdata;
               fer_pkg::CSR_STARTUP_CODE: cfg_startup    = csr_wdata[3:0];
               fer_pkg::CSR_SLEEP_CODE:   cfg_sleep      = csr_wdata[3:0];
               fer_pkg::CSR_CBC_CODE:     cfg_cbc        = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            want = step_recorder(req_word);
            if (use_typed)
               want = typed_rsp;
            rsp_due_q.push_back(want);
            words_taken++;
            if (req_word.command == fer_pkg::CMD_READ)
               reads_done++;
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d responses pending",
               cycle_count, rsp_due_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // Directed script: each row is repeated reps times
   typedef struct {
      fer_pkg::req_type w;
      int unsigned      reps;
      bit               typed;
      fer_pkg::rsp_type want;
   } script_row;

   script_row script[$];

   task automatic add_row(logic [2:0] cmd, fer_pkg::ev_idx_type ev, logic [7:0] lvl,
                          logic ok, logic [8:0] off, int unsigned reps, bit typed,
                          logic sv, fer_pkg::ev_idx_type rev, logic [7:0] rdl,
                          fer_pkg::pos_type pos);
      script_row row;
      row.w     = '{command: cmd, event_id: ev, level: lvl, store_ok: ok,
                    read_offset: off};
      row.reps  = reps;
      row.typed = typed;
      row.want  = '{saved: sv, rec_event: rev, rec_delta: rdl, write_position: pos};
      script.push_back(row);
   endtask

   // Present one word from the falling edge until it is taken
   task automatic send_word(fer_pkg::req_type w, bit typed, fer_pkg::rsp_type want);
      @(negedge clock);
      start     = 1'b1;
      req_word  = w;
      use_typed = typed;
      typed_rsp = want;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // Sender goes quiet for a random stretch, with noise on the word
   task automatic sender_gap(int unsigned pct);
      if ($urandom_range(99) < pct) begin
         @(negedge clock);
         start    = 1'b0;
         req_word = fer_pkg::req_type'($urandom);
         repeat ($urandom_range(0, 3))
            @(negedge clock);
      end
   endtask

   // Hold off until every response is back, then let the pipe settle
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (rsp_due_q.size() != 0)
         @(posedge clock);
      repeat (2)
         @(posedge clock);
   endtask

   task automatic write_csr(fer_pkg::csr_index_type idx, logic [16:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = data;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Random word biased toward the configured codes and recurring levels
   function automatic fer_pkg::req_type random_word();
      fer_pkg::req_type w;
      int unsigned      pick;
      w    = fer_pkg::req_type'($urandom);
      pick = $urandom_range(99);
      if (pick < 34)
         w.command = fer_pkg::CMD_TICK;
      else if (pick < 70)
         w.command = fer_pkg::CMD_EVENT;
      else if (pick < 77)
         w.command = fer_pkg::CMD_STARTUP;
      else if (pick < 93)
         w.command = fer_pkg::CMD_READ;
      else if (pick < 95)
         w.command = fer_pkg::CMD_CLEAR;
      else
         w.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      pick = $urandom_range(99);
      if (pick < 20)
         w.event_id = cfg_startup;
      else if (pick < 35)
         w.event_id = cfg_sleep;
      else if (pick < 60)
         w.event_id = cfg_cbc;
      pick = $urandom_range(99);
      if (pick < 35)
         w.level = '0;
      else if (pick < 55)
         w.level = '1;
      else if (pick < 75)
         w.level = 8'($urandom_range(1, 3));
      w.store_ok = ($urandom_range(99) < 85);
      if ($urandom_range(1))
         w.read_offset = 9'($urandom_range(0, 7));
      return w;
   endfunction

   // Per-phase sender idling and register settings
   int unsigned phase_idle [4] = '{0, 45, 0, 34};

   initial begin : stimulus
      logic [16:0]         set_min [4];
      fer_pkg::ev_idx_type set_startup [4];
      fer_pkg::ev_idx_type set_sleep [4];
      fer_pkg::ev_idx_type set_cbc [4];
      fer_pkg::ev_idx_type shared_code;

      reset        = 1'b1;
      start        = 1'b0;
      req_word     = '0;
      use_typed    = 1'b0;
      typed_rsp    = '0;
      csr_write_en = 1'b0;
      csr_index    = fer_pkg::CSR_MIN_REPEAT;
      csr_wdata    = '0;
      fail_count    = 0;
      cycle_count   = 0;
      words_taken   = 0;
      records_saved = 0;
      reads_done    = 0;

      // Register defaults and a clean log
      cfg_min_repeat  = '0;
      cfg_startup     = EV_STARTUP_DFLT;
      cfg_sleep       = EV_SLEEP_DFLT;
      cfg_cbc         = EV_CBC_DFLT;
      interval_secs   = '0;
      uptime_secs     = '0;
      startup_pending = 1'b0;
      wipe_log();

      repeat (8)
         @(negedge clock);
      reset = 1'b0;

      // Directed part, under the reset register values.
      // Empty log reads back zero at both offset extremes.
      add_row(fer_pkg::CMD_READ, 0, 0, 0, 9'd0, 1, 1, 0, 0, DELTA_NONE, 0);
      add_row(fer_pkg::CMD_READ, 0, 0, 0, 9'd511, 1, 1, 0, 0, DELTA_NONE, 0);
      // Sleep always records
      add_row(fer_pkg::CMD_EVENT, EV_SLEEP_DFLT, 0, 1, 0, 1, 1, 1, EV_SLEEP_DFLT,
              DELTA_SHORT, 1);
      // Startup: ignored until requested, refused save keeps the request
      add_row(fer_pkg::CMD_EVENT, EV_STARTUP_DFLT, 0, 1, 0, 1, 1, 0, 0, DELTA_NONE, 1);
      add_row(fer_pkg::CMD_STARTUP, 0, 0, 0, 0, 1, 1, 0, 0, DELTA_NONE, 1);
      add_row(fer_pkg::CMD_EVENT, EV_STARTUP_DFLT, 0, 0, 0, 1, 1, 0, 0, DELTA_NONE, 1);
      add_row(fer_pkg::CMD_EVENT, EV_STARTUP_DFLT, 0, 1, 0, 1, 1, 1, EV_STARTUP_DFLT,
              DELTA_NONE, 2);
      // Cbc records only on a level change
      add_row(fer_pkg::CMD_EVENT, EV_CBC_DFLT, 0, 1, 0, 1, 1, 0, 0, DELTA_NONE, 2);
      add_row(fer_pkg::CMD_EVENT, EV_CBC_DFLT, 8'hFF, 1, 0, 1, 1, 1, EV_CBC_DFLT,
              DELTA_SHORT, 3);
      // Ordinary event: latch, hold, re-arm on zero level
      add_row(fer_pkg::CMD_EVENT, EV_TOP, 8'hFF, 1, 0, 1, 1, 1, EV_TOP, DELTA_SHORT, 4);
      add_row(fer_pkg::CMD_EVENT, EV_TOP, 8'hFF, 1, 0, 1, 1, 0, 0, DELTA_NONE, 4);
      add_row(fer_pkg::CMD_EVENT, EV_TOP, 0, 1, 0, 1, 1, 0, 0, DELTA_NONE, 4);
      // Newest first, oldest, and one past the oldest
      add_row(fer_pkg::CMD_READ, 0, 0, 0, 9'd0, 1, 1, 0, EV_TOP, DELTA_SHORT, 4);
      add_row(fer_pkg::CMD_READ, 0, 0, 0, 9'd3, 1, 1, 0, EV_SLEEP_DFLT, DELTA_SHORT, 4);
      add_row(fer_pkg::CMD_READ, 0, 0, 0, 9'd4, 1, 1, 0, 0, DELTA_NONE, 4);
      // Undefined command does nothing
      add_row(CMD_UNUSED_LO, EV_TOP, 8'hFF, 1, 9'd511, 1, 1, 0, 0, DELTA_NONE, 4);
      // Clear empties the log
      add_row(fer_pkg::CMD_CLEAR, 0, 0, 0, 0, 1, 1, 0, 0, DELTA_NONE, 0);
      add_row(fer_pkg::CMD_READ, 0, 0, 0, 9'd0, 1, 1, 0, 0, DELTA_NONE, 0);
      // Delta boundary: exactly a minute, then just over a minute
      add_row(fer_pkg::CMD_TICK, 0, 0, 0, 0, 60, 1, 0, 0, DELTA_NONE, 0);
      add_row(fer_pkg::CMD_EVENT, EV_SLEEP_DFLT, 0, 1, 0, 1, 1, 1, EV_SLEEP_DFLT,
              DELTA_SHORT, 1);
      add_row(fer_pkg::CMD_TICK, 0, 0, 0, 0, 61, 0, 0, 0, DELTA_NONE, 0);
      add_row(fer_pkg::CMD_EVENT, EV_SLEEP_DFLT, 0, 1, 0, 1, 1, 1, EV_SLEEP_DFLT, 8'd1, 2);
      add_row(fer_pkg::CMD_READ, 0, 0, 0, 9'd1, 1, 1, 0, EV_SLEEP_DFLT, DELTA_SHORT, 2);
      // Refused ordinary save must not latch
      add_row(fer_pkg::CMD_EVENT, EV_TOP, 8'h01, 0, 0, 1, 0, 0, 0, DELTA_NONE, 0);

      foreach (script[i])
         repeat (script[i].reps)
            send_word(script[i].w, script[i].typed, script[i].want);
      wait_drained();
      use_typed = 1'b0;

      // Random phases: limit and code extremes, codes that alias each other
      shared_code    = fer_pkg::ev_idx_type'($urandom_range(0, fer_pkg::EVENT_COUNT - 1));
      set_min        = '{17'($urandom_range(1, 20)), 17'd86400, 17'd0,
                         17'($urandom_range(1, 40))};
      set_startup    = '{EV_STARTUP_DFLT, EV_TOP, 4'($urandom), shared_code};
      set_sleep      = '{EV_SLEEP_DFLT, EV_TOP - 4'd1, 4'($urandom), shared_code};
      set_cbc        = '{EV_CBC_DFLT, EV_TOP - 4'd2, 4'($urandom), shared_code};

      for (int p = 0; p < 4; p++) begin
         write_csr(fer_pkg::CSR_MIN_REPEAT, set_min[p]);
         write_csr(fer_pkg::CSR_STARTUP_CODE, {13'd0, set_startup[p]});
         write_csr(fer_pkg::CSR_SLEEP_CODE, {13'd0, set_sleep[p]});
         write_csr(fer_pkg::CSR_CBC_CODE, {13'd0, set_cbc[p]});
         for (int i = 0; i < PHASE_WORDS; i++) begin
            // Occasionally let every response come back before going on
            if (i == PHASE_WORDS / 2 || $urandom_range(99) == 0)
               wait_drained();
            sender_gap(phase_idle[p]);
            send_word(random_word(), 1'b0, '0);
         end
         wait_drained();
      end

      repeat (3)
         @(posedge clock);
      if (rsp_due_q.size() != 0)
         flag_mismatch("responses never returned", 32'(rsp_due_q.size()), '0);
      $display("Covered %0d command words in the directed script and 4 register settings,",
               words_taken);
      $display("with %0d records saved and %0d records read back; %0d mismatches.",
               records_saved, reads_done, fail_count);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== fault_event_recorder.f =====
+incdir+src
src/fer_pkg.sv
src/fer_ring.sv
src/fault_event_recorder.sv
bench/tb.sv
